@@ hw/rtl/binary_to_decimal_ascii_macros.svh @@
// Assertion macros for the binary to decimal ASCII converter.
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef SYNTHESIS

`define B2D_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("b2d check failed");

`define B2D_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b2d implication failed");

`else

`define B2D_ASSERT(label, cond)

`define B2D_ASSERT_IMPL(label, ante, cons)

`endif

`endif

@@ hw/rtl/b2d_pkg.sv @@
// Shared types and constants of the binary to decimal ASCII converter.
package b2d_pkg;

  localparam int MAG_W  = 63;              // magnitude bits of a non-negative value
  localparam int NDIG   = 19;              // most decimal digits of a 63-bit magnitude
  localparam int BCD_W  = 4 * NDIG;
  localparam int IDX_W  = $clog2(NDIG);
  localparam int CNT_W  = $clog2(MAG_W + 1);
  localparam int BSZ_W  = 6;
  localparam int LEN_W  = 5;
  localparam int CHAR_W = 8;
  localparam int STAT_W = 2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_TERM  = 8'h00;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_NEG  = 2'd1;
  localparam logic [STAT_W-1:0] ST_LONG = 2'd2;

  localparam logic [1:0] KIND_NORM = 2'd0;
  localparam logic [1:0] KIND_ZERO = 2'd1;
  localparam logic [1:0] KIND_NEG  = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [MAG_W-1:0] mag;
    logic [BSZ_W-1:0] bsize;
  } b2d_item_t;

  // Producer side of a queue port
  typedef struct packed {
    logic      valid;
    b2d_item_t item;
  } b2d_qhs_t;

endpackage

@@ hw/rtl/b2d_front.sv @@
// Front end: accepts input words, classifies them and hands them to the queue.
module b2d_front
  import b2d_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [63:0]  in_value,
  input  logic [BSZ_W-1:0]    in_buffer_size,
  output b2d_qhs_t            push,
  input  logic                push_ready
);

  logic      fr_valid_r, fr_valid_nxt;
  b2d_item_t fr_item_r, fr_item_nxt;
  logic      in_acc;

  assign in_ready = !fr_valid_r || push_ready;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    fr_item_nxt  = fr_item_r;
    if (fr_valid_r && push_ready) begin
      fr_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      fr_valid_nxt       = 1'b1;
      fr_item_nxt.mag    = in_value[MAG_W-1:0];
      fr_item_nxt.bsize  = in_buffer_size;
      if (in_value[63]) begin
        fr_item_nxt.kind = KIND_NEG;
      end else if (in_value[MAG_W-1:0] == '0) begin
        fr_item_nxt.kind = KIND_ZERO;
      end else begin
        fr_item_nxt.kind = KIND_NORM;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fr_item_r <= fr_item_nxt;
  end

  assign push.valid = fr_valid_r;
  assign push.item  = fr_item_r;

endmodule

@@ hw/rtl/b2d_queue.sv @@
// Short queue between the classifier and the conversion engine.
module b2d_queue
  import b2d_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  b2d_qhs_t push,
  output logic     push_ready,
  output b2d_qhs_t head,
  input  logic     pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b2d_item_t       q_mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop, empty;

  assign empty      = (count_r == '0);
  assign push_ready = (count_r != CW'(DEPTH));
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && !empty;

  assign head.valid = !empty;
  assign head.item  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push.item;
    end
  end

endmodule

@@ hw/rtl/b2d_back.sv @@
// Back end: shift-add-3 conversion, length check and character emission.
module b2d_back
  import b2d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  b2d_qhs_t          head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char_code,
  output logic              out_last,
  output logic [STAT_W-1:0] out_status,
  output logic [LEN_W-1:0]  out_total_length
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  function automatic logic [3:0] add3(input logic [3:0] n);
    return (n >= 4'd5) ? n + 4'd3 : n;
  endfunction

  function automatic logic [LEN_W-1:0] digit_count(input logic [BCD_W-1:0] b);
    logic [LEN_W-1:0] d;
    d = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (b[i*4 +: 4] != 4'd0) begin
        d = LEN_W'(i + 1);
      end
    end
    return d;
  endfunction

  logic [2:0]        st_r, st_nxt;
  logic [MAG_W-1:0]  bin_r, bin_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [BCD_W-1:0]  adj;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BSZ_W-1:0]  bsize_r, bsize_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [STAT_W-1:0] fin_st_r, fin_st_nxt;
  logic [LEN_W-1:0]  fin_len_r, fin_len_nxt;
  logic              ov_r, ov_nxt;
  logic [CHAR_W-1:0] och_r, och_nxt;
  logic              olast_r, olast_nxt;
  logic [STAT_W-1:0] ostat_r, ostat_nxt;
  logic [LEN_W-1:0]  olen_r, olen_nxt;
  logic [LEN_W-1:0]  dcnt;
  logic [3:0]        digit;
  logic              out_free;

  assign out_free = !ov_r || out_ready;
  assign pop      = (st_r == S_IDLE) && head.valid;
  assign dcnt     = digit_count(bcd_r);
  assign digit    = bcd_r[idx_r*4 +: 4];

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i*4 +: 4] = add3(bcd_r[i*4 +: 4]);
    end
  end

  always_comb begin
    st_nxt      = st_r;
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    cnt_nxt     = cnt_r;
    bsize_nxt   = bsize_r;
    idx_nxt     = idx_r;
    fin_st_nxt  = fin_st_r;
    fin_len_nxt = fin_len_r;
    ov_nxt      = ov_r;
    och_nxt     = och_r;
    olast_nxt   = olast_r;
    ostat_nxt   = ostat_r;
    olen_nxt    = olen_r;

    // drop the output word once taken
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (st_r)
      S_IDLE: begin
        if (head.valid) begin
          bin_nxt     = head.item.mag;
          bcd_nxt     = '0;
          cnt_nxt     = CNT_W'(MAG_W);
          bsize_nxt   = head.item.bsize;
          idx_nxt     = '0;
          fin_st_nxt  = ST_OK;
          fin_len_nxt = LEN_W'(1);
          case (head.item.kind)
            KIND_NEG: begin
              fin_st_nxt  = ST_NEG;
              fin_len_nxt = '0;
              st_nxt      = S_FIN;
            end
            // zero emits a single '0' digit from the cleared BCD register
            KIND_ZERO: st_nxt = S_EMIT;
            default:   st_nxt = S_CONV;
          endcase
        end
      end
      S_CONV: begin
        bcd_nxt = {adj[BCD_W-2:0], bin_r[MAG_W-1]};
        bin_nxt = {bin_r[MAG_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          st_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if ({1'b0, dcnt} >= bsize_r) begin
          fin_st_nxt  = ST_LONG;
          fin_len_nxt = '0;
          st_nxt      = S_FIN;
        end else begin
          idx_nxt     = IDX_W'(dcnt - LEN_W'(1));
          fin_len_nxt = dcnt + LEN_W'(1);
          st_nxt      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          och_nxt   = ASCII_ZERO + {4'd0, digit};
          olast_nxt = 1'b0;
          ostat_nxt = ST_OK;
          olen_nxt  = '0;
          if (idx_r == '0) begin
            st_nxt = S_FIN;
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          och_nxt   = CHAR_TERM;
          olast_nxt = 1'b1;
          ostat_nxt = fin_st_r;
          olen_nxt  = fin_len_r;
          st_nxt    = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r     <= bin_nxt;
    bcd_r     <= bcd_nxt;
    cnt_r     <= cnt_nxt;
    bsize_r   <= bsize_nxt;
    idx_r     <= idx_nxt;
    fin_st_r  <= fin_st_nxt;
    fin_len_r <= fin_len_nxt;
    och_r     <= och_nxt;
    olast_r   <= olast_nxt;
    ostat_r   <= ostat_nxt;
    olen_r    <= olen_nxt;
  end

  assign out_valid        = ov_r;
  assign out_char_code    = och_r;
  assign out_last         = olast_r;
  assign out_status       = ostat_r;
  assign out_total_length = olen_r;

endmodule

@@ hw/rtl/binary_to_decimal_ascii.sv @@
// Negative inputs skip the conversion and go straight to the terminator; zero inputs skip
// the conversion and emit a single '0' digit. Positive values run the 63-step shift-add-3
// loop. The single conversion engine takes the next queued item only once it is back in
// idle after emitting the previous item's terminator.
// Reset: synchronous active-low rst_n clears the handshake, queue and sequencer state.
`include "binary_to_decimal_ascii_macros.svh"
module binary_to_decimal_ascii
  import b2d_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [63:0] in_value,
  input  logic [BSZ_W-1:0]   in_buffer_size,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  out_char_code,
  output logic               out_last,
  output logic [STAT_W-1:0]  out_status,
  output logic [LEN_W-1:0]   out_total_length
);

  b2d_qhs_t push;
  b2d_qhs_t head;
  logic     push_ready;
  logic     pop;

  b2d_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_buffer_size (in_buffer_size),
    .push           (push),
    .push_ready     (push_ready)
  );

  b2d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  b2d_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char_code    (out_char_code),
    .out_last         (out_last),
    .out_status       (out_status),
    .out_total_length (out_total_length)
  );

  `B2D_ASSERT_IMPL(a_last_is_term, out_valid && out_last, out_char_code == CHAR_TERM)
  `B2D_ASSERT_IMPL(a_digit_char, out_valid && !out_last, out_char_code - ASCII_ZERO < 8'd10)
  `B2D_ASSERT_IMPL(a_digit_meta, out_valid && !out_last, out_status == ST_OK && out_total_length == '0)
  `B2D_ASSERT_IMPL(a_len_status, out_valid && out_last, (out_status == ST_OK) == (out_total_length != '0))
  `B2D_ASSERT(a_pop_has_head, !pop || head.valid)

endmodule

@@ tb/binary_to_decimal_ascii_tb.sv @@
// Self-checking testbench for the binary to decimal ASCII converter.
`timescale 1ns / 100ps

module binary_to_decimal_ascii_tb
  import b2d_pkg::*;
();

  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 120;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic signed [63:0] value;
    logic [BSZ_W-1:0]   bsize;
  } conv_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  total_length;
  } char_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [63:0] in_value = '0;
  logic [BSZ_W-1:0]   in_buffer_size = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CHAR_W-1:0]  out_char_code;
  logic               out_last;
  logic [STAT_W-1:0]  out_status;
  logic [LEN_W-1:0]   out_total_length;

  conv_item_t pending_convs[$];
  char_word_t expected_chars[$];
  int         send_idle_pct = 23;
  int         recv_idle_pct = 79;
  int         mismatch_cnt = 0;
  int         cycle_cnt = 0;
  int         hold_left = 0;
  bit         hold_req = 1'b0;
  bit         in_accepted = 1'b0;

  binary_to_decimal_ascii i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_buffer_size   (in_buffer_size),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char_code    (out_char_code),
    .out_last         (out_last),
    .out_status       (out_status),
    .out_total_length (out_total_length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void expect_char(input logic [CHAR_W-1:0] ch, input logic last,
                                      input logic [STAT_W-1:0] st, input logic [LEN_W-1:0] len);
    char_word_t w;
    w.char_code    = ch;
    w.last         = last;
    w.status       = st;
    w.total_length = len;
    expected_chars.push_back(w);
  endfunction

  // Work out the characters one conversion produces.
  function automatic void predict_conversion(input logic [63:0] value,
                                             input logic [BSZ_W-1:0] bsize);
    logic [63:0] rest;
    logic [3:0]  digits [NDIG];
    int          ndig;
    if (value[63]) begin
      expect_char(CHAR_TERM, 1'b1, ST_NEG, '0);
    end else if (value == 64'd0) begin
      expect_char(ASCII_ZERO, 1'b0, ST_OK, '0);
      expect_char(CHAR_TERM, 1'b1, ST_OK, LEN_W'(1));
    end else begin
      rest = value;
      ndig = 0;
      while (rest != 64'd0) begin
        digits[ndig] = 4'(rest % 64'd10);
        rest = rest / 64'd10;
        ndig++;
      end
      if (ndig >= int'(bsize)) begin
        expect_char(CHAR_TERM, 1'b1, ST_LONG, '0);
      end else begin
        for (int k = ndig - 1; k >= 0; k--) begin
          expect_char(CHAR_W'(ASCII_ZERO + digits[k]), 1'b0, ST_OK, '0);
        end
        expect_char(CHAR_TERM, 1'b1, ST_OK, LEN_W'(ndig + 1));
      end
    end
  endfunction

  task automatic queue_conv(input logic [63:0] value, input int bsize);
    conv_item_t item;
    item.value = value;
    item.bsize = BSZ_W'(bsize);
    pending_convs.push_back(item);
  endtask

  // Mostly positive values of every length, buffer sizes around the digit count.
  task automatic queue_random_convs(input int count);
    logic [63:0] mag;
    logic [63:0] value;
    logic [63:0] rest;
    int          ndig;
    int          bsize;
    int          sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      mag = {$urandom, $urandom};
      if (sel < 10) begin
        value = mag | 64'h8000_0000_0000_0000;
      end else if (sel < 16) begin
        value = '0;
      end else begin
        value = {1'b0, mag[62:0]} >> $urandom_range(62);
      end
      rest = value;
      ndig = 0;
      while (rest != 64'd0 && !value[63]) begin
        rest = rest / 64'd10;
        ndig++;
      end
      if (sel >= 16 && $urandom_range(3) != 0) begin
        bsize = ndig - 1 + int'($urandom_range(4));
        if (bsize < 0) bsize = 0;
      end else begin
        bsize = $urandom_range(63);
      end
      queue_conv(value, bsize);
    end
  endtask

  // Wait at a rising edge so the driver's pop and valid updates have settled.
  task automatic wait_drained(input bit need_results);
    do begin
      @(posedge clk);
    end while (pending_convs.size() != 0 || in_valid ||
               (need_results && expected_chars.size() != 0));
  endtask

  // Sender: hold the word until it is taken, then offer the next one or idle.
  always @(negedge clk) begin : drive_input
    conv_item_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      in_accepted = 1'b0;
      if (pending_convs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item = pending_convs.pop_front();
        in_valid       <= 1'b1;
        in_value       <= item.value;
        in_buffer_size <= item.bsize;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : watch_ports
    char_word_t w;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_conversion(in_value, in_buffer_size);
        in_accepted = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("unexpected word: char %h last %b status %0d len %0d",
                     out_char_code, out_last, out_status, out_total_length);
          mismatch_cnt++;
        end else begin
          w = expected_chars.pop_front();
          if (out_char_code !== w.char_code || out_last !== w.last ||
              out_status !== w.status || out_total_length !== w.total_length) begin
            if (mismatch_cnt < 10)
              $display({"mismatch: exp char %h last %b status %0d len %0d,",
                        " got char %h last %b status %0d len %0d"},
                       w.char_code, w.last, w.status, w.total_length,
                       out_char_code, out_last, out_status, out_total_length);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero, buffer size extremes, digit count boundaries, negatives, largest value.
    queue_conv(64'd0, 0);
    queue_conv(64'd0, 63);
    queue_conv(64'd1, 2);
    queue_conv(64'd1, 1);
    queue_conv(64'd1, 0);
    queue_conv(64'd9, 2);
    queue_conv(64'd10, 2);
    queue_conv(64'd10, 3);
    queue_conv(64'd100, 3);
    queue_conv(64'd100, 4);
    queue_conv(64'h7FFF_FFFF_FFFF_FFFF, 20);
    queue_conv(64'h7FFF_FFFF_FFFF_FFFF, 19);
    queue_conv(64'h7FFF_FFFF_FFFF_FFFF, 63);
    queue_conv(64'h8000_0000_0000_0000, 32);
    queue_conv(64'hFFFF_FFFF_FFFF_FFFF, 32);
    queue_conv(64'hFFFF_FFFF_FFFF_FFFF, 0);
    queue_conv(64'd999999999999999999, 19);
    queue_conv(64'd1000000000000000000, 20);
    queue_conv(64'd1000000000000000000, 32);
    queue_conv(64'd12345678901234567, 18);
    queue_conv(64'h5555_5555_5555_5555, 33);
    wait_drained(1'b0);

    queue_random_convs(160);
    wait_drained(1'b0);
    send_idle_pct = 79;
    recv_idle_pct = 23;
    queue_random_convs(160);

    // Let every result come out before the full-rate phase.
    wait_drained(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    queue_random_convs(150);

    wait_drained(1'b1);
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatch_cnt += expected_chars.size();
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
